// File: src/keyed_record_table_defines.svh
// assertion macros used by the checker file
`ifndef KEYED_RECORD_TABLE_DEFINES_SVH
`define KEYED_RECORD_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define KRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed_record_table check failed");

// next-cycle implication, disabled while reset is low
`define KRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed_record_table check failed");

`endif

// File: src/krt_pkg.sv
package krt_pkg;

  // default table depth
  localparam int unsigned KRT_DEPTH = 32;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_LIST   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // one stored record
  typedef struct packed {
    logic [31:0] key;
    logic [63:0] data;
  } entry_t;

  // one result transaction
  typedef struct packed {
    status_e     status;
    logic [4:0]  position;
    logic [31:0] key;
    logic [63:0] data;
    logic        last;
  } result_t;

endpackage

// File: src/krt_mem.sv
module krt_mem import krt_pkg::*; #(
  parameter int unsigned DEPTH = KRT_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/krt_ctrl.sv
module krt_ctrl import krt_pkg::*; #(
  parameter int unsigned DEPTH = KRT_DEPTH,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    action_i,
  input  logic [31:0]   key_i,
  input  logic [63:0]   record_data_i,
  input  logic          slot_free_i,
  output logic          emit_o,
  output result_t       result_o,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output entry_t        mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  entry_t        mem_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_HIT,
    S_MISS,
    S_SH_RD,
    S_SH_WR,
    S_LIST_RD,
    S_LIST_EMIT,
    S_EMPTY
  } state_e;

  state_e        state_q;
  action_e       action_q;
  logic [31:0]   key_q;
  logic [63:0]   data_q;
  logic [AW-1:0] idx_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_p2;
  logic          full;

  // low five bits of an entry index
  function automatic logic [4:0] to_pos(input logic [AW-1:0] idx);
    logic [AW+4:0] wide;
    wide = {5'd0, idx};
    return wide[4:0];
  endfunction

  assign idx_p1 = CW'(idx_q) + CW'(1);
  assign idx_p2 = idx_p1 + CW'(1);
  assign full   = (count_q == CW'(DEPTH));

  // memory access and result for the current state
  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    emit_o      = 1'b0;
    result_o    = '{status: ST_OK, position: '0, key: '0, data: '0, last: 1'b1};
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    unique case (state_q)
      S_ADD: begin
        emit_o = 1'b1;
        if (full) begin
          result_o.status = ST_FULL;
        end else begin
          result_o.position = to_pos(count_q[AW-1:0]);
          result_o.key      = key_q;
          result_o.data     = data_q;
          mem_we_o          = slot_free_i;
          mem_waddr_o       = count_q[AW-1:0];
          mem_wdata_o       = '{key: key_q, data: data_q};
        end
      end
      S_SCAN_RD, S_LIST_RD: begin
        mem_re_o = 1'b1;
      end
      S_HIT: begin
        emit_o            = 1'b1;
        result_o.position = to_pos(idx_q);
        result_o.key      = mem_rdata_i.key;
        result_o.data     = mem_rdata_i.data;
      end
      S_MISS: begin
        emit_o          = 1'b1;
        result_o.status = ST_NOT_FOUND;
      end
      S_EMPTY: begin
        emit_o          = 1'b1;
        result_o.status = ST_EMPTY;
      end
      S_SH_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_p1[AW-1:0];
      end
      S_SH_WR: begin
        mem_we_o = 1'b1;
      end
      S_LIST_EMIT: begin
        emit_o            = 1'b1;
        result_o.position = to_pos(idx_q);
        result_o.key      = mem_rdata_i.key;
        result_o.data     = mem_rdata_i.data;
        result_o.last     = (idx_p1 == count_q);
      end
      default: begin
      end
    endcase
  end

  // sequencer state, index and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      action_q <= ACT_ADD;
      key_q    <= '0;
      data_q   <= '0;
      idx_q    <= '0;
      count_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            action_q <= action_e'(action_i);
            key_q    <= key_i;
            data_q   <= record_data_i;
            idx_q    <= '0;
            unique case (action_e'(action_i))
              ACT_ADD: state_q <= S_ADD;
              ACT_SEARCH, ACT_DELETE: begin
                state_q <= (count_q == '0) ? S_MISS : S_SCAN_RD;
              end
              ACT_LIST: begin
                state_q <= (count_q == '0) ? S_EMPTY : S_LIST_RD;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (slot_free_i) begin
            if (!full) begin
              count_q <= count_q + CW'(1);
            end
            state_q <= S_IDLE;
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (mem_rdata_i.key == key_q) begin
            state_q <= S_HIT;
          end else if (idx_p1 == count_q) begin
            state_q <= S_MISS;
          end else begin
            idx_q   <= idx_p1[AW-1:0];
            state_q <= S_SCAN_RD;
          end
        end
        S_HIT: begin
          if (slot_free_i) begin
            if (action_q != ACT_DELETE) begin
              state_q <= S_IDLE;
            end else if (idx_p1 == count_q) begin
              count_q <= count_q - CW'(1);
              state_q <= S_IDLE;
            end else begin
              state_q <= S_SH_RD;
            end
          end
        end
        S_MISS, S_EMPTY: begin
          if (slot_free_i) begin
            state_q <= S_IDLE;
          end
        end
        // move the later entries down one place
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          idx_q <= idx_p1[AW-1:0];
          if (idx_p2 == count_q) begin
            count_q <= count_q - CW'(1);
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SH_RD;
          end
        end
        S_LIST_RD: state_q <= S_LIST_EMIT;
        S_LIST_EMIT: begin
          if (slot_free_i) begin
            if (idx_p1 == count_q) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_p1[AW-1:0];
              state_q <= S_LIST_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/krt_out.sv
module krt_out import krt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    emit_i,
  input  result_t result_i,
  output logic    slot_free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q;
  result_t res_q;

  // slot can take a result when empty or being drained this cycle
  assign slot_free_o = !valid_q || !out_stall_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (slot_free_o) begin
      valid_q <= emit_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (slot_free_o && emit_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

// File: src/keyed_record_table.sv
// keyed record table: up to DEPTH records of a 32-bit key and a 64-bit data word,
// kept packed in arrival order in one synchronous memory.
// input channel (in_valid_i / in_stall_o) takes one action per transaction:
// add, search, delete or list. in_stall_o is high while an action is in work.
// output channel (out_valid_o / out_stall_i) carries results from one register;
// add, search and delete give one result, list one per entry, last_o marks the
// final result of an action. non-ok results carry zero position, key and data.
// actions work through the entries one at a time over the single memory read
// port: add writes the record after the last entry unless the table is full;
// search reads and compares each entry in order until a key matches; delete
// then moves each later entry down one place with a read and a write; list
// reads and emits each entry in turn, or gives one empty result if none.
// a stall on the output holds the result register and pauses the sequencer
// at its next result; work resumes as soon as the register drains.
// reset empties the table at once (entry count cleared, no clearing pass) and
// drops any result that was waiting.
module keyed_record_table import krt_pkg::*; #(
  parameter int unsigned DEPTH = KRT_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] key_i,
  input  logic [63:0]        record_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [4:0]         position_o,
  output logic signed [31:0] found_key_o,
  output logic [63:0]        found_data_o,
  output logic               last_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic          slot_free;
  logic          emit;
  result_t       emit_res;
  result_t       out_res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  // sequencer
  krt_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .key_i         (key_i),
    .record_data_i (record_data_i),
    .slot_free_i   (slot_free),
    .emit_o        (emit),
    .result_o      (emit_res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  // record store
  krt_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result register
  krt_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .result_i    (emit_res),
    .slot_free_o (slot_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign status_o     = out_res.status;
  assign position_o   = out_res.position;
  assign found_key_o  = out_res.key;
  assign found_data_o = out_res.data;
  assign last_o       = out_res.last;

endmodule

// File: src/krt_chk.sv
`include "keyed_record_table_defines.svh"

module krt_chk import krt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         action_i,
  input logic signed [31:0] key_i,
  input logic [63:0]        record_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic [4:0]         position_o,
  input logic signed [31:0] found_key_o,
  input logic [63:0]        found_data_o,
  input logic               last_o
);

  // a stalled result holds until taken
  `KRT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(found_key_o) && $stable(found_data_o))

  // an error or empty result always closes its action
  `KRT_ASSERT_NOW(a_err_last, clk_i, rst_ni, out_valid_o && status_o != ST_OK, last_o)

  // error and empty results carry no entry
  `KRT_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_valid_o && status_o != ST_OK, position_o == '0 && found_key_o == '0 && found_data_o == '0)

  // one action at a time: accepting a transaction closes the input
  `KRT_ASSERT_NEXT(a_one_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind keyed_record_table krt_chk u_krt_chk (.*);
